/* sv/rcpwm_pkg.sv */
package rcpwm_pkg;

    // Field widths
    localparam int PULSE_W = 16;
    localparam int DETECT_W = 4;
    localparam int STABLE_W = 3;
    localparam int CFG_INDEX_W = 3;

    // Acquisition and stability thresholds
    localparam logic [PULSE_W-1:0] VALID_LOW = 16'd798;
    localparam logic [PULSE_W-1:0] VALID_HIGH = 16'd2202;
    localparam logic [DETECT_W-1:0] DETECT_COUNT = 4'd10;
    localparam logic [STABLE_W-1:0] STABLE_COUNT = 3'd5;
    localparam logic [PULSE_W-1:0] STABLE_WINDOW = 16'd10;
    localparam logic [DETECT_W-1:0] DETECT_MAX = 4'd15;
    localparam logic [STABLE_W-1:0] STABLE_MAX = 3'd7;

    // Band bound reset values
    localparam logic [PULSE_W-1:0] ARM_LOW_RST = 16'd900;
    localparam logic [PULSE_W-1:0] ARM_HIGH_RST = 16'd1100;
    localparam logic [PULSE_W-1:0] DROP_ONE_LOW_RST = 16'd1400;
    localparam logic [PULSE_W-1:0] DROP_ONE_HIGH_RST = 16'd1600;
    localparam logic [PULSE_W-1:0] DROP_ALL_LOW_RST = 16'd1900;
    localparam logic [PULSE_W-1:0] DROP_ALL_HIGH_RST = 16'd2100;

    // Command codes
    typedef enum logic [1:0] {
        CMD_NONE     = 2'd0,
        CMD_DROP_ONE = 2'd1,
        CMD_DROP_ALL = 2'd2
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ARM_LOW       = 3'd0,
        REG_ARM_HIGH      = 3'd1,
        REG_DROP_ONE_LOW  = 3'd2,
        REG_DROP_ONE_HIGH = 3'd3,
        REG_DROP_ALL_LOW  = 3'd4,
        REG_DROP_ALL_HIGH = 3'd5
    } reg_index_t;

    // Band bounds handed from the register file to the decoder
    typedef struct packed {
        logic [PULSE_W-1:0] arm_low;
        logic [PULSE_W-1:0] arm_high;
        logic [PULSE_W-1:0] drop_one_low;
        logic [PULSE_W-1:0] drop_one_high;
        logic [PULSE_W-1:0] drop_all_low;
        logic [PULSE_W-1:0] drop_all_high;
    } band_cfg_t;

    // Strict inside test against exclusive bounds
    function automatic logic in_band(
        input logic [PULSE_W-1:0] p,
        input logic [PULSE_W-1:0] lo,
        input logic [PULSE_W-1:0] hi
    );
        return (p > lo) && (p < hi);
    endfunction

endpackage

/* sv/rcpwm_cfg.sv */
module rcpwm_cfg
    import rcpwm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PULSE_W-1:0]     cfg_data,
    output band_cfg_t              bands
);

    band_cfg_t bands_reg;
    band_cfg_t bands_next;

    // Decode the write index; drop writes beyond the register list
    always_comb
    begin
        bands_next = bands_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ARM_LOW:       bands_next.arm_low = cfg_data;
                REG_ARM_HIGH:      bands_next.arm_high = cfg_data;
                REG_DROP_ONE_LOW:  bands_next.drop_one_low = cfg_data;
                REG_DROP_ONE_HIGH: bands_next.drop_one_high = cfg_data;
                REG_DROP_ALL_LOW:  bands_next.drop_all_low = cfg_data;
                REG_DROP_ALL_HIGH: bands_next.drop_all_high = cfg_data;
                default:           bands_next = bands_reg;
            endcase
        end
    end

    // Hold the band bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bands_reg.arm_low <= ARM_LOW_RST;
            bands_reg.arm_high <= ARM_HIGH_RST;
            bands_reg.drop_one_low <= DROP_ONE_LOW_RST;
            bands_reg.drop_one_high <= DROP_ONE_HIGH_RST;
            bands_reg.drop_all_low <= DROP_ALL_LOW_RST;
            bands_reg.drop_all_high <= DROP_ALL_HIGH_RST;
        end
        else
        begin
            bands_reg <= bands_next;
        end
    end

    assign bands = bands_reg;

endmodule

/* sv/rcpwm_decode.sv */
module rcpwm_decode
    import rcpwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [PULSE_W-1:0] pulse,
    input  band_cfg_t          bands,
    output cmd_t               command,
    output logic               mode_locked,
    output logic               armed_now
);

    logic                locked_reg, locked_next;
    logic [DETECT_W-1:0] detect_count_reg, detect_count_next;
    logic [PULSE_W-1:0]  reference_reg, reference_next;
    logic [STABLE_W-1:0] stable_count_reg, stable_count_next;
    logic                armed_reg, armed_next;
    cmd_t                command_reg, command_next;

    logic [DETECT_W-1:0] detect_inc;
    logic [STABLE_W-1:0] stable_inc;
    logic [PULSE_W-1:0]  delta;

    // Saturating counts and distance to the reference pulse
    always_comb
    begin
        detect_inc = (detect_count_reg == DETECT_MAX) ? detect_count_reg
                                                      : detect_count_reg + 4'd1;
        stable_inc = (stable_count_reg == STABLE_MAX) ? stable_count_reg
                                                      : stable_count_reg + 3'd1;
        delta = (pulse >= reference_reg) ? pulse - reference_reg
                                         : reference_reg - pulse;
    end

    // Acquire, track stability and decode the command bands
    always_comb
    begin
        locked_next = locked_reg;
        detect_count_next = detect_count_reg;
        reference_next = reference_reg;
        stable_count_next = stable_count_reg;
        armed_next = armed_reg;
        command_next = CMD_NONE;

        if (!locked_reg)
        begin
            if (in_band(pulse, VALID_LOW, VALID_HIGH))
            begin
                detect_count_next = detect_inc;
                if (detect_inc >= DETECT_COUNT)
                begin
                    locked_next = 1'b1;
                end
            end
            else
            begin
                detect_count_next = '0;
            end
        end
        else if (delta < STABLE_WINDOW)
        begin
            stable_count_next = stable_inc;
            if (stable_inc >= STABLE_COUNT)
            begin
                stable_count_next = '0;
                if (in_band(pulse, bands.arm_low, bands.arm_high))
                begin
                    armed_next = 1'b1;
                end
                else if (armed_reg)
                begin
                    if (in_band(pulse, bands.drop_one_low, bands.drop_one_high))
                    begin
                        armed_next = 1'b0;
                        command_next = CMD_DROP_ONE;
                    end
                    else if (in_band(pulse, bands.drop_all_low, bands.drop_all_high))
                    begin
                        armed_next = 1'b0;
                        command_next = CMD_DROP_ALL;
                    end
                end
            end
        end
        else
        begin
            reference_next = pulse;
            stable_count_next = '0;
        end
    end

    // Advance state and the result on each stepped transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg <= 1'b0;
            detect_count_reg <= '0;
            reference_reg <= '0;
            stable_count_reg <= '0;
            armed_reg <= 1'b0;
            command_reg <= CMD_NONE;
        end
        else if (step)
        begin
            locked_reg <= locked_next;
            detect_count_reg <= detect_count_next;
            reference_reg <= reference_next;
            stable_count_reg <= stable_count_next;
            armed_reg <= armed_next;
            command_reg <= command_next;
        end
    end

    assign command = command_reg;
    assign mode_locked = locked_reg;
    assign armed_now = armed_reg;

endmodule

/* sv/rc_pwm_command_decoder_top.sv */
// RC servo PWM command decoder. Each input transaction carries one measured
// high-pulse width in microseconds and yields exactly one result transaction:
// the command issued (none, drop one, drop all), the lock flag and the armed
// flag after that pulse. The block first acquires a run of pulses inside the
// valid window, then decodes pulses that have been stable against a
// reference for several in a row into arm and drop commands. It takes one
// pulse per clock while in_stall is low. The pulse is held in the input
// register and then passes through the compare logic into the result
// register, which also holds the decoder state. The result register parts
// the two sides, so a new pulse is taken while a result waits, and in_stall
// rises only when both registers are full and out_stall is high.
// Band bounds are written through the cfg port (index 0..5, others ignored)
// and should be changed only while no transaction is in flight.
module rc_pwm_command_decoder_top
    import rcpwm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PULSE_W-1:0]     pulse_width,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             command,
    output logic                   mode_locked,
    output logic                   armed_now,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PULSE_W-1:0]     cfg_data
);

    logic               in_valid_reg, in_valid_next;
    logic [PULSE_W-1:0] pulse_reg;
    logic               out_valid_reg, out_valid_next;
    logic               advance;
    logic               in_take;
    band_cfg_t          bands;
    cmd_t               command_res;

    // Move a transaction into the result register when it is free or drains
    assign advance = !out_valid_reg || !out_stall;
    assign in_take = in_valid && !in_stall;
    assign in_stall = in_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
            in_valid_next = 1'b0;
        end
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
    end

    // Hold handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the pulse width of an accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pulse_reg <= pulse_width;
        end
    end

    rcpwm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bands     (bands)
    );

    rcpwm_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance && in_valid_reg),
        .pulse       (pulse_reg),
        .bands       (bands),
        .command     (command_res),
        .mode_locked (mode_locked),
        .armed_now   (armed_now)
    );

    assign command = command_res;
    assign out_valid = out_valid_reg;

endmodule

/* dv/tb_top.sv */
module tb_top;
    import rcpwm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS = 26;

    // Indexes past the last band register; the block must ignore them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        cmd_t cmd;
        logic locked;
        logic armed;
    } decode_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse;
        bit                 typed;
        decode_t            want;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [PULSE_W-1:0]     pulse_width;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             command;
    logic                   mode_locked;
    logic                   armed_now;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [PULSE_W-1:0]     cfg_data;

    // Band bounds and decoder state as the block should hold them
    band_cfg_t          bands;
    logic               m_locked;
    logic [DETECT_W-1:0] m_detect;
    logic [PULSE_W-1:0] m_ref;
    logic [STABLE_W-1:0] m_stable;
    logic               m_armed;

    decode_t pending_decodes[$];
    int      err_count;
    int      out_count;
    int      cycle_count;
    bit      idle_en;
    int      stall_left;

    // Directed pulses: acquisition, lock, arm, drop one
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{16'd0,     1'b1, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd65535, 1'b1, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd799,   1'b1, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd798,   1'b1, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd799,   1'b1, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd2201,  1'b1, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1500,  1'b1, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1500,  1'b1, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1500,  1'b1, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1500,  1'b1, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1500,  1'b1, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1500,  1'b1, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1500,  1'b1, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd2201,  1'b1, '{CMD_NONE, 1'b1, 1'b0}},
        '{16'd1000,  1'b0, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1009,  1'b0, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd991,   1'b0, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1000,  1'b0, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1000,  1'b0, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1000,  1'b1, '{CMD_NONE, 1'b1, 1'b1}},
        '{16'd1500,  1'b0, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1509,  1'b0, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1491,  1'b0, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1500,  1'b0, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1500,  1'b0, '{CMD_NONE, 1'b0, 1'b0}},
        '{16'd1500,  1'b1, '{CMD_DROP_ONE, 1'b1, 1'b0}}
    };

    rc_pwm_command_decoder_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pulse_width (pulse_width),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .command     (command),
        .mode_locked (mode_locked),
        .armed_now   (armed_now),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Strict test against exclusive bounds
    function automatic bit band_hit(
        input logic [PULSE_W-1:0] p,
        input logic [PULSE_W-1:0] lo,
        input logic [PULSE_W-1:0] hi
    );
        return (p > lo) && (p < hi);
    endfunction

    // Advance the decoder state by one pulse and return its result
    function automatic decode_t decode_pulse(input logic [PULSE_W-1:0] p);
        decode_t            r;
        logic [PULSE_W-1:0] gap;
        r.cmd = CMD_NONE;
        if (!m_locked)
        begin
            if (p > VALID_LOW && p < VALID_HIGH)
            begin
                if (m_detect != DETECT_MAX)
                    m_detect = m_detect + 1'b1;
                if (m_detect >= DETECT_COUNT)
                    m_locked = 1'b1;
            end
            else
                m_detect = '0;
        end
        else
        begin
            gap = (p >= m_ref) ? p - m_ref : m_ref - p;
            if (gap < STABLE_WINDOW)
            begin
                if (m_stable != STABLE_MAX)
                    m_stable = m_stable + 1'b1;
                if (m_stable >= STABLE_COUNT)
                begin
                    // Decode: arm band first, then drop one, then drop all
                    m_stable = '0;
                    if (band_hit(p, bands.arm_low, bands.arm_high))
                        m_armed = 1'b1;
                    else if (m_armed)
                    begin
                        if (band_hit(p, bands.drop_one_low, bands.drop_one_high))
                        begin
                            m_armed = 1'b0;
                            r.cmd = CMD_DROP_ONE;
                        end
                        else if (band_hit(p, bands.drop_all_low, bands.drop_all_high))
                        begin
                            m_armed = 1'b0;
                            r.cmd = CMD_DROP_ALL;
                        end
                    end
                end
            end
            else
            begin
                m_ref = p;
                m_stable = '0;
            end
        end
        r.locked = m_locked;
        r.armed = m_armed;
        return r;
    endfunction

    function automatic logic [PULSE_W-1:0] clamp_us(input int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return 16'hFFFF;
        return PULSE_W'(v);
    endfunction

    // Point strictly inside a band, or anywhere when the band is empty
    function automatic int band_point(input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi);
        if (int'(hi) > int'(lo) + 1)
            return $urandom_range(int'(lo) + 1, int'(hi) - 1);
        return $urandom_range(0, 65535);
    endfunction

    // Center value for one pulse train, biased toward the bands and their edges
    function automatic int pick_center();
        int e;
        case ($urandom_range(0, 7))
            0, 1: return band_point(bands.arm_low, bands.arm_high);
            2, 3: return band_point(bands.drop_one_low, bands.drop_one_high);
            4: return band_point(bands.drop_all_low, bands.drop_all_high);
            5:
            begin
                case ($urandom_range(0, 5))
                    0: e = bands.arm_low;
                    1: e = bands.arm_high;
                    2: e = bands.drop_one_low;
                    3: e = bands.drop_one_high;
                    4: e = bands.drop_all_low;
                    default: e = bands.drop_all_high;
                endcase
                return clamp_us(e + $urandom_range(0, 2) - 1);
            end
            6: return $urandom_range(0, 65535);
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return 0;
                    1: return 65535;
                    2: return int'(VALID_LOW) + $urandom_range(0, 2) - 1;
                    default: return int'(VALID_HIGH) + $urandom_range(0, 2) - 1;
                endcase
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb_top: result %0d %s got %0d expected %0d", out_count, what, got, want);
        err_count++;
    endtask

    // Send one pulse transaction and queue what it should produce
    task automatic send_pulse(input logic [PULSE_W-1:0] p, input bit typed, input decode_t want);
        decode_t pred;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pulse_width <= p;
        do @(posedge clk); while (in_stall);
        pred = decode_pulse(p);
        pending_decodes.push_back(typed ? want : pred);
    endtask

    // Random part: mostly steady pulse trains around a center, some noise
    task automatic send_pulse_trains(input int n, input bit calm);
        int sent;
        int c;
        int len;
        int j;
        sent = 0;
        while (sent < n)
        begin
            if (!calm)
                idle_en <= ($urandom_range(0, 5) != 0);
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_pulse(PULSE_W'($urandom_range(0, 65535)), 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                c = pick_center();
                len = $urandom_range(5, 7);
                send_pulse(clamp_us(c), 1'b0, '0);
                sent++;
                repeat (len)
                begin
                    case ($urandom_range(0, 7))
                        0, 1, 2, 3: j = 0;
                        7: j = $urandom_range(0, 24) - 12;
                        default: j = $urandom_range(0, 18) - 9;
                    endcase
                    send_pulse(clamp_us(c + j), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // Hold the block idle until every queued result has come back
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [PULSE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_ARM_LOW:       bands.arm_low = data;
            REG_ARM_HIGH:      bands.arm_high = data;
            REG_DROP_ONE_LOW:  bands.drop_one_low = data;
            REG_DROP_ONE_HIGH: bands.drop_one_high = data;
            REG_DROP_ALL_LOW:  bands.drop_all_low = data;
            REG_DROP_ALL_HIGH: bands.drop_all_high = data;
            default: ;
        endcase
    endtask

    task automatic write_bands(input band_cfg_t b, input bit stray);
        write_reg(REG_ARM_LOW, b.arm_low);
        write_reg(REG_ARM_HIGH, b.arm_high);
        if (stray)
            write_reg(REG_SPARE_6, PULSE_W'($urandom_range(0, 65535)));
        write_reg(REG_DROP_ONE_LOW, b.drop_one_low);
        write_reg(REG_DROP_ONE_HIGH, b.drop_one_high);
        write_reg(REG_DROP_ALL_LOW, b.drop_all_low);
        write_reg(REG_DROP_ALL_HIGH, b.drop_all_high);
        if (stray)
            write_reg(REG_SPARE_7, PULSE_W'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
    endtask

    // Random band pair, sometimes inverted
    task automatic random_band(output logic [PULSE_W-1:0] lo, output logic [PULSE_W-1:0] hi);
        int a;
        int b;
        a = $urandom_range(0, 65535);
        b = a + $urandom_range(0, 400);
        if ($urandom_range(0, 3) == 0)
        begin
            lo = clamp_us(b);
            hi = clamp_us(a);
        end
        else
        begin
            lo = clamp_us(a);
            hi = clamp_us(b);
        end
    endtask

    // Result stall in bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_en && $urandom_range(0, 4) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end
        else
            out_stall <= 1'b0;
    end

    // Check each result transaction against the oldest pending decode
    always @(posedge clk)
    begin : result_check
        decode_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_decodes.size() == 0)
                report_mismatch("with nothing pending, command", command, 0);
            else
            begin
                want = pending_decodes.pop_front();
                if (command !== want.cmd)
                    report_mismatch("command", command, want.cmd);
                if (mode_locked !== want.locked)
                    report_mismatch("mode_locked", mode_locked, want.locked);
                if (armed_now !== want.armed)
                    report_mismatch("armed_now", armed_now, want.armed);
            end
            out_count++;
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        band_cfg_t b;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pulse_width = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_en = 1'b1;
        stall_left = 0;
        err_count = 0;
        out_count = 0;
        cycle_count = 0;
        bands.arm_low = ARM_LOW_RST;
        bands.arm_high = ARM_HIGH_RST;
        bands.drop_one_low = DROP_ONE_LOW_RST;
        bands.drop_one_high = DROP_ONE_HIGH_RST;
        bands.drop_all_low = DROP_ALL_LOW_RST;
        bands.drop_all_high = DROP_ALL_HIGH_RST;
        m_locked = 1'b0;
        m_detect = '0;
        m_ref = '0;
        m_stable = '0;
        m_armed = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset bands, then random trains
        foreach (dir_rows[i])
            send_pulse(dir_rows[i].pulse, dir_rows[i].typed, dir_rows[i].want);
        send_pulse_trains(140, 1'b0);
        drain_block();

        // Widest bands: every stable pulse but the extremes arms
        b.arm_low = '0;
        b.arm_high = 16'hFFFF;
        b.drop_one_low = '0;
        b.drop_one_high = 16'hFFFF;
        b.drop_all_low = '0;
        b.drop_all_high = 16'hFFFF;
        write_bands(b, 1'b1);
        send_pulse_trains(80, 1'b0);
        drain_block();

        // Single-value arm band, empty drop-one band, drop-all over everything
        b.arm_low = 16'd1000;
        b.arm_high = 16'd1002;
        b.drop_one_low = 16'd1500;
        b.drop_one_high = 16'd1501;
        b.drop_all_low = '0;
        b.drop_all_high = 16'hFFFF;
        write_bands(b, 1'b0);
        send_pulse_trains(80, 1'b0);
        drain_block();

        // Random bands, some inverted or overlapping
        repeat (3)
        begin
            random_band(b.arm_low, b.arm_high);
            random_band(b.drop_one_low, b.drop_one_high);
            random_band(b.drop_all_low, b.drop_all_high);
            write_bands(b, 1'b1);
            send_pulse_trains(40, 1'b0);
            drain_block();
        end

        // Reset bands again, no idling on either side
        b.arm_low = ARM_LOW_RST;
        b.arm_high = ARM_HIGH_RST;
        b.drop_one_low = DROP_ONE_LOW_RST;
        b.drop_one_high = DROP_ONE_HIGH_RST;
        b.drop_all_low = DROP_ALL_LOW_RST;
        b.drop_all_high = DROP_ALL_HIGH_RST;
        write_bands(b, 1'b0);
        idle_en <= 1'b0;
        send_pulse_trains(100, 1'b1);
        drain_block();

        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
